// File: hw/rtl/ptf_pkg.sv
// Shared types, constants and frame helpers for the periodic telemetry framer.
package ptf_pkg;

    localparam int unsigned FRAME_BYTES = 25;
    localparam int unsigned CRC_SPAN    = 21;
    localparam int unsigned HEX_CHARS   = 2 * FRAME_BYTES;
    localparam int unsigned CHAR_IDX_W  = $clog2(HEX_CHARS);
    localparam int unsigned BYTE_IDX_W  = $clog2(FRAME_BYTES);

    localparam int unsigned INTERVAL_W  = 27;
    localparam int unsigned DEV_ID_W    = 16;
    localparam int unsigned CFG_DATA_W  = INTERVAL_W;
    localparam int unsigned CFG_IDX_W   = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_ID       = 2'd2;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 27'd1000;

    localparam logic [7:0] HDR0     = 8'hA5;
    localparam logic [7:0] HDR1     = 8'hB6;
    localparam logic [7:0] FR_TYPE  = 8'h02;
    localparam logic [7:0] CMD_HI   = 8'h03;
    localparam logic [7:0] CMD_LO   = 8'h02;
    localparam logic [7:0] FR_LEN   = 8'h0C;
    localparam logic [7:0] FR_VER   = 8'h02;
    localparam logic [7:0] TAIL0    = 8'hB6;
    localparam logic [7:0] TAIL1    = 8'hA5;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [CHAR_IDX_W-1:0] LAST_CHAR_IDX = CHAR_IDX_W'(HEX_CHARS - 1);
    localparam logic [BYTE_IDX_W-1:0] CRC_LAST_BYTE = BYTE_IDX_W'(CRC_SPAN - 1);

    // one due report waiting to be framed
    typedef struct packed {
        logic [DEV_ID_W-1:0] unit_id;
        logic [31:0]         unix_time;
        logic [31:0]         ch0_bits;
        logic [31:0]         ch1_bits;
    } t_rec;

    // control between front and queue
    typedef struct packed {
        logic push;
        logic full;
    } t_q_wr;

    typedef struct packed {
        logic pop;
        logic avail;
    } t_q_rd;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10) begin
            r = 8'h30 + {4'h0, nib};
        end else begin
            r = 8'h37 + {4'h0, nib};
        end
        return r;
    endfunction

    function automatic logic [7:0] frame_byte(input t_rec rec, input logic [15:0] crc,
                                              input logic [BYTE_IDX_W-1:0] b);
        logic [7:0] r;
        unique case (b)
            5'd0:    r = HDR0;
            5'd1:    r = HDR1;
            5'd2:    r = rec.unit_id[15:8];
            5'd3:    r = rec.unit_id[7:0];
            5'd4:    r = FR_TYPE;
            5'd5:    r = CMD_HI;
            5'd6:    r = CMD_LO;
            5'd7:    r = FR_LEN;
            5'd8:    r = FR_VER;
            5'd9:    r = rec.unix_time[31:24];
            5'd10:   r = rec.unix_time[23:16];
            5'd11:   r = rec.unix_time[15:8];
            5'd12:   r = rec.unix_time[7:0];
            5'd13:   r = rec.ch0_bits[31:24];
            5'd14:   r = rec.ch0_bits[23:16];
            5'd15:   r = rec.ch0_bits[15:8];
            5'd16:   r = rec.ch0_bits[7:0];
            5'd17:   r = rec.ch1_bits[31:24];
            5'd18:   r = rec.ch1_bits[23:16];
            5'd19:   r = rec.ch1_bits[15:8];
            5'd20:   r = rec.ch1_bits[7:0];
            5'd21:   r = crc[15:8];
            5'd22:   r = crc[7:0];
            5'd23:   r = TAIL0;
            5'd24:   r = TAIL1;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// File: hw/rtl/ptf_poll_if.sv
// Poll channel: valid/ready handshake with the four poll fields.
interface ptf_poll_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic [31:0] unix_time;
    logic [31:0] ch0_bits;
    logic [31:0] ch1_bits;

    modport source (output valid, now_ms, unix_time, ch0_bits, ch1_bits, input ready);
    modport sink   (input valid, now_ms, unix_time, ch0_bits, ch1_bits, output ready);
endinterface

// File: hw/rtl/ptf_char_if.sv
// Character channel: valid/ready handshake with one ASCII hex character.
interface ptf_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] hex_char;
    logic       last_char;

    modport source (output valid, hex_char, last_char, input ready);
    modport sink   (input valid, hex_char, last_char, output ready);
endinterface

// File: hw/rtl/ptf_front.sv
// Front end: configuration registers, due check and report time tracking.
module ptf_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [ptf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ptf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ptf_poll_if.sink                      i_poll,
    input  ptf_pkg::t_q_wr                i_q_stat,
    output ptf_pkg::t_q_wr                o_q_ctl,
    output ptf_pkg::t_rec                 o_rec
);
    import ptf_pkg::*;

    logic                  r_report_enable;
    logic [INTERVAL_W-1:0] r_min_gap;
    logic [DEV_ID_W-1:0]   r_unit_id;
    logic [31:0]           r_last_report_ms;

    logic [31:0] elapsed;
    logic        due;
    logic        beat;

    assign i_poll.ready = !i_q_stat.full;
    assign beat         = i_poll.valid && i_poll.ready;
    assign elapsed      = i_poll.now_ms - r_last_report_ms;
    assign due          = r_report_enable && (elapsed >= {5'd0, r_min_gap});

    assign o_q_ctl.push = beat && due;
    assign o_q_ctl.full = i_q_stat.full;

    assign o_rec.unit_id   = r_unit_id;
    assign o_rec.unix_time = i_poll.unix_time;
    assign o_rec.ch0_bits  = i_poll.ch0_bits;
    assign o_rec.ch1_bits  = i_poll.ch1_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_report_enable  <= 1'b0;
            r_min_gap        <= INTERVAL_RESET;
            r_unit_id        <= '0;
            r_last_report_ms <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_idx)
                    CFG_REPORT_ENABLE: r_report_enable <= i_cfg_data[0];
                    CFG_MIN_GAP:       r_min_gap       <= i_cfg_data[INTERVAL_W-1:0];
                    CFG_UNIT_ID:       r_unit_id       <= i_cfg_data[DEV_ID_W-1:0];
                    default:           ;
                endcase
            end
            // remember the time of the last report sent
            if (beat && due) begin
                r_last_report_ms <= i_poll.now_ms;
            end
        end
    end

endmodule

// File: hw/rtl/ptf_queue.sv
// Two-entry queue of due reports between front end and character generator.
module ptf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ptf_pkg::t_q_wr i_wr,
    input  ptf_pkg::t_rec  i_rec,
    output ptf_pkg::t_q_wr o_wr_stat,
    input  ptf_pkg::t_q_rd i_rd,
    output ptf_pkg::t_q_rd o_rd_stat,
    output ptf_pkg::t_rec  o_rec
);
    import ptf_pkg::*;

    t_rec       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic do_push;
    logic do_pop;

    assign do_push = i_wr.push && (r_count != 2'd2);
    assign do_pop  = i_rd.pop && (r_count != 2'd0);

    assign o_wr_stat.push  = do_push;
    assign o_wr_stat.full  = (r_count == 2'd2);
    assign o_rd_stat.pop   = do_pop;
    assign o_rd_stat.avail = (r_count != 2'd0);
    assign o_rec           = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: hw/rtl/ptf_back.sv
// Back end: walks a frame one hex character a beat, folding bytes into the CRC.
module ptf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ptf_pkg::t_q_rd i_q_stat,
    input  ptf_pkg::t_rec  i_rec,
    output ptf_pkg::t_q_rd o_q_ctl,
    ptf_char_if.source     o_char
);
    import ptf_pkg::*;

    t_rec                  r_rec;
    logic                  r_busy;
    logic [CHAR_IDX_W-1:0] r_idx;
    logic [15:0]           r_crc;
    logic                  r_out_valid;
    logic [7:0]            r_hex_char;
    logic                  r_last_char;

    logic                  load;
    logic                  finishing;
    logic                  take;
    logic [BYTE_IDX_W-1:0] byte_idx;
    logic [7:0]            cur_byte;
    logic [3:0]            cur_nib;

    assign load      = !r_out_valid || o_char.ready;
    assign finishing = r_busy && load && (r_idx == LAST_CHAR_IDX);
    assign take      = i_q_stat.avail && (!r_busy || finishing);

    assign o_q_ctl.pop   = take;
    assign o_q_ctl.avail = i_q_stat.avail;

    assign byte_idx = r_idx[CHAR_IDX_W-1:1];
    assign cur_byte = frame_byte(r_rec, r_crc, byte_idx);
    assign cur_nib  = r_idx[0] ? cur_byte[3:0] : cur_byte[7:4];

    assign o_char.valid     = r_out_valid;
    assign o_char.hex_char  = r_hex_char;
    assign o_char.last_char = r_last_char;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_rec <= i_rec;
        end
        if (r_busy && load) begin
            r_hex_char  <= hex_ascii(cur_nib);
            r_last_char <= (r_idx == LAST_CHAR_IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_crc       <= CRC_INIT;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= r_busy;
            end
            if (take) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
                r_crc  <= CRC_INIT;
            end else if (finishing) begin
                r_busy <= 1'b0;
            end else if (r_busy && load) begin
                r_idx <= r_idx + CHAR_IDX_W'(1);
                // fold each covered byte once its low nibble goes out
                if (r_idx[0] && (byte_idx <= CRC_LAST_BYTE)) begin
                    r_crc <= crc16_byte(r_crc, cur_byte);
                end
            end
        end
    end

endmodule

// File: hw/rtl/periodic_telemetry_framer.sv
// A due report passes from the poll beat into a queue slot, the back-end record register
// and the character output register. Throughput: polls are taken one per cycle while the
// queue is not full; a due report sends 50 characters at one per cycle while the receiver
// is ready. The two-entry report queue lets polls continue while a frame is being sent.
// Reset (synchronous, active low) empties the queue, ends any frame in flight,
// turns reporting off, sets a 1000 ms minimum gap, unit id 0 and last report time 0.
module periodic_telemetry_framer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [ptf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ptf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ptf_poll_if.sink                       i_poll,
    ptf_char_if.source                     o_char
);
    import ptf_pkg::*;

    t_q_wr front_q_ctl;
    t_q_wr q_wr_stat;
    t_q_rd back_q_ctl;
    t_q_rd q_rd_stat;
    t_rec  front_rec;
    t_rec  q_rec;

    ptf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_poll      (i_poll),
        .i_q_stat    (q_wr_stat),
        .o_q_ctl     (front_q_ctl),
        .o_rec       (front_rec)
    );

    ptf_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (front_q_ctl),
        .i_rec     (front_rec),
        .o_wr_stat (q_wr_stat),
        .i_rd      (back_q_ctl),
        .o_rd_stat (q_rd_stat),
        .o_rec     (q_rec)
    );

    ptf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_rd_stat),
        .i_rec    (q_rec),
        .o_q_ctl  (back_q_ctl),
        .o_char   (o_char)
    );

endmodule

// File: verif/periodic_telemetry_framer_tb.sv
// Self-checking testbench for the periodic telemetry framer: random polls, frame prediction.
module periodic_telemetry_framer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ptf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_A    = 8'h41;
    localparam int SETTLE     = 8;
    localparam int QUIET_MAX  = 2000;
    localparam int RAND_POLLS = 400;

    typedef enum logic [1:0] {STIM_POLL, STIM_WRITE, STIM_DRAIN} t_stim_kind;

    typedef struct {
        t_stim_kind             kind;
        logic [31:0]            now_ms;
        logic [31:0]            unix_time;
        logic [31:0]            ch0_bits;
        logic [31:0]            ch1_bits;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_data;
        int unsigned            pace;
    } t_stim;

    typedef struct {
        logic [7:0] hex_char;
        logic       last_char;
    } t_char_exp;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    ptf_poll_if poll_ch ();
    ptf_char_if char_ch ();

    periodic_telemetry_framer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_poll      (poll_ch),
        .o_char      (char_ch)
    );

    // stimulus plan and expected characters
    t_stim       plan [$];
    t_char_exp   chars_due [$];

    // predictor copy of registers and report time
    logic                  en_reg;
    logic [INTERVAL_W-1:0] interval_reg;
    logic [DEV_ID_W-1:0]   dev_id_reg;
    logic [31:0]           last_sent_ms;

    int unsigned pace_now;
    int          since_poll;
    int          quiet_cycles;
    logic        timed_out;
    int          fail_count;
    int          polls_taken;
    int          frames_seen;
    int          chars_seen;
    int          writes_done;
    int unsigned fill_pace;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] nibble_char(input logic [3:0] nib);
        return (nib < 4'd10) ? ASCII_ZERO + {4'h0, nib} : ASCII_A + {4'h0, nib} - 8'd10;
    endfunction

    // decide whether a poll is due and queue the fifty characters of its frame
    function automatic void predict_poll(input t_stim s);
        logic [7:0]  fr [FRAME_BYTES];
        logic [15:0] crc;
        logic [31:0] since_ms;
        t_char_exp   c;
        since_ms = s.now_ms - last_sent_ms;
        if (!en_reg || since_ms < {5'b0, interval_reg}) begin
            return;
        end
        last_sent_ms = s.now_ms;
        fr[0]  = HDR0;
        fr[1]  = HDR1;
        fr[2]  = dev_id_reg[15:8];
        fr[3]  = dev_id_reg[7:0];
        fr[4]  = FR_TYPE;
        fr[5]  = CMD_HI;
        fr[6]  = CMD_LO;
        fr[7]  = FR_LEN;
        fr[8]  = FR_VER;
        for (int i = 0; i < 4; i++) begin
            fr[9 + i]  = s.unix_time[31 - 8*i -: 8];
            fr[13 + i] = s.ch0_bits[31 - 8*i -: 8];
            fr[17 + i] = s.ch1_bits[31 - 8*i -: 8];
        end
        crc = CRC_INIT;
        for (int i = 0; i < CRC_SPAN; i++) begin
            crc = crc ^ {8'h00, fr[i]};
            for (int k = 0; k < 8; k++) begin
                crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
            end
        end
        fr[21] = crc[15:8];
        fr[22] = crc[7:0];
        fr[23] = TAIL0;
        fr[24] = TAIL1;
        for (int i = 0; i < FRAME_BYTES; i++) begin
            c.hex_char  = nibble_char(fr[i][7:4]);
            c.last_char = 1'b0;
            chars_due.push_back(c);
            c.hex_char  = nibble_char(fr[i][3:0]);
            c.last_char = (i == FRAME_BYTES - 1);
            chars_due.push_back(c);
        end
    endfunction

    task automatic add_poll(input logic [31:0] now, input logic [31:0] ts,
                            input logic [31:0] c0, input logic [31:0] c1);
        t_stim s;
        s = '{STIM_POLL, now, ts, c0, c1, '0, '0, fill_pace};
        plan.push_back(s);
    endtask

    task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        t_stim s;
        s = '{STIM_WRITE, '0, '0, '0, '0, idx, data, fill_pace};
        plan.push_back(s);
    endtask

    task automatic add_drain();
        t_stim s;
        s = '{STIM_DRAIN, '0, '0, '0, '0, '0, '0, fill_pace};
        plan.push_back(s);
    endtask

    // poll driver and configuration writer
    always @(posedge i_clk) begin : drive_polls
        static t_stim cur;
        static t_stim s;
        static int    gap_left = 0;
        logic         v_nxt;
        logic         wr_nxt;
        static logic [CFG_IDX_W-1:0]  w_idx  = '0;
        static logic [CFG_DATA_W-1:0] w_data = '0;
        if (!i_rst_n) begin
            poll_ch.valid     <= 1'b0;
            poll_ch.now_ms    <= '0;
            poll_ch.unix_time <= '0;
            poll_ch.ch0_bits  <= '0;
            poll_ch.ch1_bits  <= '0;
            cfg_wr_en         <= 1'b0;
            cfg_idx           <= '0;
            cfg_data          <= '0;
            en_reg       = 1'b0;
            interval_reg = INTERVAL_RESET;
            dev_id_reg   = '0;
            last_sent_ms = '0;
            since_poll   = SETTLE;
            cur          = '{STIM_POLL, '0, '0, '0, '0, '0, '0, 0};
        end else begin
            v_nxt  = poll_ch.valid;
            wr_nxt = 1'b0;
            if (poll_ch.valid && poll_ch.ready) begin
                predict_poll(cur);
                polls_taken++;
                since_poll = 0;
                v_nxt = 1'b0;
                if (cur.pace != 0 && $urandom_range(0, 5 - 2 * cur.pace) == 0) begin
                    gap_left = $urandom_range(1, 16);
                end
            end else if (since_poll < SETTLE) begin
                since_poll++;
            end
            if (!v_nxt) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (plan.size() > 0) begin
                    s = plan[0];
                    case (s.kind)
                        STIM_POLL: begin
                            cur   = s;
                            v_nxt = 1'b1;
                            pace_now <= s.pace;
                            void'(plan.pop_front());
                        end
                        STIM_WRITE: begin
                            // registers change only once the block has gone quiet
                            if (chars_due.size() == 0 && since_poll >= SETTLE) begin
                                case (s.reg_idx)
                                    CFG_REPORT_ENABLE: en_reg       = s.reg_data[0];
                                    CFG_MIN_GAP:       interval_reg = s.reg_data[INTERVAL_W-1:0];
                                    CFG_UNIT_ID:       dev_id_reg   = s.reg_data[DEV_ID_W-1:0];
                                    default:           ;
                                endcase
                                wr_nxt = 1'b1;
                                w_idx  = s.reg_idx;
                                w_data = s.reg_data;
                                writes_done++;
                                void'(plan.pop_front());
                            end
                        end
                        default: begin
                            if (chars_due.size() == 0 && since_poll >= SETTLE) begin
                                void'(plan.pop_front());
                            end
                        end
                    endcase
                end
            end
            poll_ch.valid     <= v_nxt;
            poll_ch.now_ms    <= cur.now_ms;
            poll_ch.unix_time <= cur.unix_time;
            poll_ch.ch0_bits  <= cur.ch0_bits;
            poll_ch.ch1_bits  <= cur.ch1_bits;
            cfg_wr_en         <= wr_nxt;
            cfg_idx           <= w_idx;
            cfg_data          <= w_data;
        end
    end

    // character monitor with random back-pressure
    always @(posedge i_clk) begin : watch_chars
        static int stall_left = 0;
        logic      r_nxt;
        t_char_exp e;
        if (!i_rst_n) begin
            char_ch.ready <= 1'b0;
        end else begin
            if (char_ch.valid && char_ch.ready) begin
                chars_seen++;
                if (chars_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected char %h (last %b) with nothing pending",
                                 char_ch.hex_char, char_ch.last_char);
                    end
                end else begin
                    e = chars_due.pop_front();
                    if (e.hex_char !== char_ch.hex_char || e.last_char !== char_ch.last_char) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("char %0d: expected %h last %b, got %h last %b",
                                     chars_seen - 1, e.hex_char, e.last_char,
                                     char_ch.hex_char, char_ch.last_char);
                        end
                    end
                    if (e.last_char) begin
                        frames_seen++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                r_nxt = 1'b0;
            end else if (pace_now != 0 && $urandom_range(0, 12 - 4 * pace_now) == 0) begin
                stall_left = $urandom_range(0, 15);
                r_nxt = 1'b0;
            end else begin
                r_nxt = 1'b1;
            end
            char_ch.ready <= r_nxt;
        end
    end

    // abandon the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((poll_ch.valid && poll_ch.ready) || (char_ch.valid && char_ch.ready)
                     || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_MAX) begin
                timed_out <= 1'b1;
            end
        end
    end

    initial begin : run
        logic [31:0] t;
        logic [31:0] iv;
        int          polls_left;
        int          n;
        int          pick;
        logic        en;
        logic [31:0] stride;

        i_rst_n           = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_idx           = '0;
        cfg_data          = '0;
        poll_ch.valid     = 1'b0;
        poll_ch.now_ms    = '0;
        poll_ch.unix_time = '0;
        poll_ch.ch0_bits  = '0;
        poll_ch.ch1_bits  = '0;
        char_ch.ready     = 1'b0;
        timed_out         = 1'b0;
        pace_now          = 1;
        fail_count  = 0;
        polls_taken = 0;
        frames_seen = 0;
        chars_seen  = 0;
        writes_done = 0;

        // directed: reset settings, window edges, wrap, extreme registers
        fill_pace = 1;
        add_poll(32'h0000_5000, 32'h1234_5678, 32'h3F80_0000, 32'h4000_0000);
        add_write(CFG_REPORT_ENABLE, 27'h2AA_AAAB);
        add_poll(32'd999, 32'h6000_0000, 32'h3F80_0000, 32'hBF80_0000);
        add_poll(32'd1000, 32'h6000_0000, 32'h3F80_0000, 32'hBF80_0000);
        add_poll(32'd1999, 32'h6000_0001, 32'h0000_0000, 32'h0000_0000);
        add_poll(32'd2000, 32'h6000_0002, 32'h7F80_0000, 32'hFF80_0000);
        add_write(CFG_UNUSED, 27'h7FF_FFFF);
        add_write(CFG_UNIT_ID, 27'h7FF_FFFF);
        add_poll(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_poll(32'd0, 32'd0, 32'd0, 32'd0);
        add_poll(32'd998, 32'd1, 32'd2, 32'd3);
        add_poll(32'd999, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0001);
        add_write(CFG_MIN_GAP, 27'd0);
        add_poll(32'd999, 32'd0, 32'd0, 32'd0);
        add_poll(32'd999, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h0F0F_0F0F);
        add_write(CFG_UNIT_ID, 27'd0);
        add_write(CFG_MIN_GAP, 27'h7FF_FFFF);
        t = 32'd999;
        add_poll(t + 32'h07FF_FFFE, 32'h0000_0001, 32'hC0C0_C0C0, 32'h3C3C_3C3C);
        t = t + 32'h07FF_FFFF;
        add_poll(t, 32'hF0F0_F0F0, 32'h0000_FFFF, 32'hFFFF_0000);
        add_write(CFG_MIN_GAP, 27'd86400000);
        add_poll(t + 32'd86399999, 32'd5, 32'd6, 32'd7);
        t = t + 32'd86400000;
        add_poll(t, 32'h5F5E_1000, 32'h4049_0FDB, 32'hC049_0FDB);
        add_write(CFG_REPORT_ENABLE, 27'd0);
        add_poll(t + 32'h8000_0000, 32'd8, 32'd9, 32'd10);
        add_write(CFG_REPORT_ENABLE, 27'd1);
        add_write(CFG_MIN_GAP, 27'd1);
        t = t + 32'd1;
        add_poll(t, 32'h0102_0304, 32'h0506_0708, 32'h090A_0B0C);
        add_poll(t, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333);
        add_drain();

        // random phases: fresh settings, then polls that step around the interval
        polls_left = RAND_POLLS;
        while (polls_left > 0) begin
            n  = (polls_left <= 60) ? polls_left : $urandom_range(25, 50);
            en = ($urandom_range(0, 7) != 0) || (polls_left <= 60);
            fill_pace = (polls_left <= 60) ? 0 : $urandom_range(0, 2);
            pick = $urandom_range(0, 7);
            case (pick)
                0:       iv = 32'd0;
                1:       iv = 32'd1;
                2:       iv = $urandom_range(2, 50);
                3:       iv = 32'd1000;
                4:       iv = 32'd86400000;
                5:       iv = 32'h07FF_FFFF;
                default: iv = $urandom_range(1, 5000);
            endcase
            add_write(CFG_REPORT_ENABLE, CFG_DATA_W'({$urandom_range(0, 32'h3FF_FFFF), en}));
            add_write(CFG_MIN_GAP, iv[INTERVAL_W-1:0]);
            add_write(CFG_UNIT_ID, CFG_DATA_W'($urandom));
            if ($urandom_range(0, 3) == 0) begin
                add_write(CFG_UNUSED, CFG_DATA_W'($urandom));
            end
            if ($urandom_range(0, 3) == 0) begin
                // run the millisecond counter across its wrap
                t = 32'hFFFF_FFFF - $urandom_range(0, 3 * iv + 3);
            end
            if (!en) begin
                n = $urandom_range(5, 12);
            end
            for (int i = 0; i < n; i++) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    t = $urandom;
                end else begin
                    if (pick == 1 && iv > 0) begin
                        stride = iv - 1;
                    end else if (pick == 2) begin
                        stride = iv;
                    end else begin
                        stride = $urandom_range(0, 2 * iv + 1);
                    end
                    t = t + stride;
                end
                add_poll(t, $urandom, $urandom, $urandom);
                if (fill_pace != 0 && $urandom_range(0, 40) == 0) begin
                    add_drain();
                end
            end
            if (en) begin
                polls_left -= n;
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!timed_out && !(plan.size() == 0 && !poll_ch.valid && chars_due.size() == 0
                               && since_poll >= SETTLE)) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);

        if (timed_out) begin
            $display("no handshake for %0d cycles, %0d polls still planned", QUIET_MAX,
                     plan.size());
        end
        if (chars_due.size() != 0) begin
            fail_count++;
            $display("%0d predicted chars never arrived", chars_due.size());
        end
        $display("polls %0d, register writes %0d, frames %0d, chars %0d, mismatches %0d",
                 polls_taken, writes_done, frames_seen, chars_seen, fail_count);
        $display("covered disabled/not-due/due polls, zero to maximum intervals, time wrap");
        if (!timed_out && fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/ptf_pkg.sv
hw/rtl/ptf_poll_if.sv
hw/rtl/ptf_char_if.sv
hw/rtl/ptf_front.sv
hw/rtl/ptf_queue.sv
hw/rtl/ptf_back.sv
hw/rtl/periodic_telemetry_framer.sv
verif/periodic_telemetry_framer_tb.sv
